[rtl/prt_pkg.sv]
package prt_pkg;

   // field widths
   localparam int COORD_W = 32;
   localparam int QUAT_W  = 18;
   localparam int CSR_W   = 32;

   // rotation matrix entries, Q.32 with room for a quaternion that is not unit
   localparam int QPROD_W = 2 * QUAT_W;
   localparam int ROT_W   = QPROD_W + 2;

   // point split into a signed high half and an unsigned low half
   localparam int HALF_W  = COORD_W / 2;
   localparam int PROD_W  = ROT_W + HALF_W + 1;
   localparam int SUM_W   = PROD_W + 2;
   localparam int RND_W   = SUM_W + 1;
   localparam int RES_W   = RND_W - HALF_W + 1;

   localparam logic signed [ROT_W-1:0]  ROT_ONE  = ROT_W'(64'sh1_0000_0000);
   localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(32'sh1_0000);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [QUAT_W-1:0]  quat_type;
   typedef logic signed [ROT_W-1:0]   rot_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   // register map of the configuration port
   typedef enum logic [2:0] {
      CSR_QUAT_W  = 3'd0,
      CSR_QUAT_X  = 3'd1,
      CSR_QUAT_Y  = 3'd2,
      CSR_QUAT_Z  = 3'd3,
      CSR_SHIFT_X = 3'd4,
      CSR_SHIFT_Y = 3'd5,
      CSR_SHIFT_Z = 3'd6
   } csr_index_type;

endpackage

[rtl/point_rigid_transform_top.sv]
// channel | direction | handshake              | word
// req     | in        | req_valid / req_stall  | point_x, point_y, point_z, end_of_cloud
// rsp     | out       | rsp_valid / rsp_stall  | out_x, out_y, out_z, end_of_cloud_out
// csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// one point per cycle sustained while rsp_stall is low; a point passes stages 1, 2, 3 and the result register
// the stages are cut around the 38x16 and 38x17 partial products of R*p and the two adder levels behind them
// each stage holds a word while the one behind it is full, so bubbles are squeezed out
// reset (synchronous) gives the identity transform and empties the pipeline
// R is rebuilt from the quaternion in the cycle of a csr write and registered in rot_ff at the edge ending it
module point_rigid_transform_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  prt_pkg::coord_type      req_point_x,
   input  prt_pkg::coord_type      req_point_y,
   input  prt_pkg::coord_type      req_point_z,
   input  logic                    req_end_of_cloud,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output prt_pkg::coord_type      rsp_out_x,
   output prt_pkg::coord_type      rsp_out_y,
   output prt_pkg::coord_type      rsp_out_z,
   output logic                    rsp_end_of_cloud_out,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  prt_pkg::csr_index_type  csr_index,
   input  logic [prt_pkg::CSR_W-1:0] csr_data
);
   import prt_pkg::*;

   // configuration registers
   quat_type  quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;
   quat_type  quat_w_in, quat_x_in, quat_y_in, quat_z_in;
   coord_type shift_ff [3];
   coord_type shift_in [3];

   // rotation matrix, follows the quaternion registers
   rot_type rot_ff [3][3];
   rot_type rot_in [3][3];

   // pipeline valids and the stage enables
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic ready1, ready2, ready3, ready_out;

   // stage 1: registered point
   coord_type p1_ff [3];
   logic      eoc1_ff;

   // stage 2: partial products, high and low halves of the point
   prod_type  hi2_ff [3][3];
   prod_type  lo2_ff [3][3];
   prod_type  hi2_in [3][3];
   prod_type  lo2_in [3][3];
   logic      eoc2_ff;

   // stage 3: row sums
   sum_type   a3_ff [3];
   sum_type   b3_ff [3];
   sum_type   a3_in [3];
   sum_type   b3_in [3];
   logic      eoc3_ff;

   // result register
   coord_type out_ff [3];
   coord_type out_in [3];
   logic      eoc_out_ff;

   logic csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // ---------------------------------------------------------------
   // configuration writes; index beyond the map is dropped
   // ---------------------------------------------------------------
   always_comb begin
      quat_w_in = quat_w_ff;
      quat_x_in = quat_x_ff;
      quat_y_in = quat_y_ff;
      quat_z_in = quat_z_ff;
      shift_in  = shift_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_QUAT_W:  quat_w_in   = csr_data[QUAT_W-1:0];
            CSR_QUAT_X:  quat_x_in   = csr_data[QUAT_W-1:0];
            CSR_QUAT_Y:  quat_y_in   = csr_data[QUAT_W-1:0];
            CSR_QUAT_Z:  quat_z_in   = csr_data[QUAT_W-1:0];
            CSR_SHIFT_X: shift_in[0] = csr_data[COORD_W-1:0];
            CSR_SHIFT_Y: shift_in[1] = csr_data[COORD_W-1:0];
            CSR_SHIFT_Z: shift_in[2] = csr_data[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // rotation matrix from the next quaternion, no normalization
   // ---------------------------------------------------------------
   always_comb begin
      logic signed [QPROD_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
      xx = quat_x_in * quat_x_in;
      yy = quat_y_in * quat_y_in;
      zz = quat_z_in * quat_z_in;
      xy = quat_x_in * quat_y_in;
      xz = quat_x_in * quat_z_in;
      yz = quat_y_in * quat_z_in;
      wx = quat_w_in * quat_x_in;
      wy = quat_w_in * quat_y_in;
      wz = quat_w_in * quat_z_in;
      rot_in[0][0] = ROT_ONE - ((ROT_W'(yy) + ROT_W'(zz)) <<< 1);
      rot_in[0][1] = (ROT_W'(xy) - ROT_W'(wz)) <<< 1;
      rot_in[0][2] = (ROT_W'(xz) + ROT_W'(wy)) <<< 1;
      rot_in[1][0] = (ROT_W'(xy) + ROT_W'(wz)) <<< 1;
      rot_in[1][1] = ROT_ONE - ((ROT_W'(xx) + ROT_W'(zz)) <<< 1);
      rot_in[1][2] = (ROT_W'(yz) - ROT_W'(wx)) <<< 1;
      rot_in[2][0] = (ROT_W'(xz) - ROT_W'(wy)) <<< 1;
      rot_in[2][1] = (ROT_W'(yz) + ROT_W'(wx)) <<< 1;
      rot_in[2][2] = ROT_ONE - ((ROT_W'(xx) + ROT_W'(yy)) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_w_ff <= QUAT_ONE;
         quat_x_ff <= '0;
         quat_y_ff <= '0;
         quat_z_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            shift_ff[i] <= '0;
            for (int j = 0; j < 3; j++) begin
               rot_ff[i][j] <= (i == j) ? ROT_ONE : '0;
            end
         end
      end else begin
         quat_w_ff <= quat_w_in;
         quat_x_ff <= quat_x_in;
         quat_y_ff <= quat_y_in;
         quat_z_ff <= quat_z_in;
         shift_ff  <= shift_in;
         rot_ff    <= rot_in;
      end
   end

   // ---------------------------------------------------------------
   // stage enables: a stage loads when empty or when its word moves on
   // ---------------------------------------------------------------
   assign ready_out = ~rsp_valid_ff | ~rsp_stall;
   assign ready3    = ~v3_ff | ready_out;
   assign ready2    = ~v2_ff | ready3;
   assign ready1    = ~v1_ff | ready2;
   assign req_stall = ~ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready1)    v1_ff        <= req_valid;
         if (ready2)    v2_ff        <= v1_ff;
         if (ready3)    v3_ff        <= v2_ff;
         if (ready_out) rsp_valid_ff <= v3_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: r * high half (signed) and r * low half (unsigned)
   // ---------------------------------------------------------------
   always_comb begin
      logic signed [HALF_W-1:0] ph [3];
      logic signed [HALF_W:0]   pl [3];
      for (int c = 0; c < 3; c++) begin
         ph[c] = p1_ff[c][COORD_W-1:HALF_W];
         pl[c] = {1'b0, p1_ff[c][HALF_W-1:0]};
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            hi2_in[r][c] = PROD_W'(rot_ff[r][c]) * PROD_W'(ph[c]);
            lo2_in[r][c] = PROD_W'(rot_ff[r][c]) * PROD_W'(pl[c]);
         end
      end
   end

   // stage 3: row sums of each half
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         a3_in[r] = SUM_W'(hi2_ff[r][0]) + SUM_W'(hi2_ff[r][1]) + SUM_W'(hi2_ff[r][2]);
         b3_in[r] = SUM_W'(lo2_ff[r][0]) + SUM_W'(lo2_ff[r][1]) + SUM_W'(lo2_ff[r][2]);
      end
   end

   // result: round to nearest (ties up), add translation, saturate
   always_comb begin
      logic signed [RND_W-1:0] rnd;
      logic signed [RES_W-1:0] res;
      for (int r = 0; r < 3; r++) begin
         rnd = RND_W'(a3_ff[r]) + RND_W'(b3_ff[r] >>> HALF_W)
             + RND_W'(33'sd32768);
         res = RES_W'(rnd >>> HALF_W) + RES_W'(shift_ff[r]);
         if (res > RES_W'(33'sd2147483647)) begin
            out_in[r] = 32'sh7fff_ffff;
         end else if (res < RES_W'(-33'sd2147483648)) begin
            out_in[r] = 32'sh8000_0000;
         end else begin
            out_in[r] = res[COORD_W-1:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ready1) begin
         p1_ff[0] <= req_point_x;
         p1_ff[1] <= req_point_y;
         p1_ff[2] <= req_point_z;
         eoc1_ff  <= req_end_of_cloud;
      end
      if (ready2) begin
         hi2_ff  <= hi2_in;
         lo2_ff  <= lo2_in;
         eoc2_ff <= eoc1_ff;
      end
      if (ready3) begin
         a3_ff   <= a3_in;
         b3_ff   <= b3_in;
         eoc3_ff <= eoc2_ff;
      end
      if (ready_out) begin
         out_ff     <= out_in;
         eoc_out_ff <= eoc3_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_x            = out_ff[0];
   assign rsp_out_y            = out_ff[1];
   assign rsp_out_z            = out_ff[2];
   assign rsp_end_of_cloud_out = eoc_out_ff;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   // a full pipe behind a stalled result must push back on the input
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && v1_ff && v2_ff && v3_ff) |-> req_stall)
      else $error("input taken while pipeline full and stalled");

   // a word held in stage 1 is not dropped while stage 2 is blocked
   a_hold_s1: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !ready2) |=> v1_ff)
      else $error("stage 1 word lost");

   // the last stage always hands its word to the result register when it can
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && ready_out) |=> rsp_valid)
      else $error("stage 3 word not delivered");

   // a write of a zero w with zero x, y, z is reflected in rot_ff: R[0][0] stays one and R[1][0] zero
   a_rot_track: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_index == CSR_QUAT_W && csr_data[QUAT_W-1:0] == '0
       && quat_x_in == '0 && quat_y_in == '0 && quat_z_in == '0)
      |=> (rot_ff[0][0] == ROT_ONE && rot_ff[1][0] == '0))
      else $error("rotation matrix out of step with quaternion");
endmodule
